>>> design/idll_pkg.sv
// Package with the request and result types and the codes of the indexed linked list.
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

  // Action codes
  localparam logic [2:0] ACT_INS_AFTER  = 3'd0;
  localparam logic [2:0] ACT_INS_BEFORE = 3'd1;
  localparam logic [2:0] ACT_REMOVE     = 3'd2;
  localparam logic [2:0] ACT_READ_SLOT  = 3'd3;
  localparam logic [2:0] ACT_READ_NTH   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  position;
    logic [63:0] value;
  } idll_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [63:0] data;
    logic [7:0]  head_slot;
    logic [7:0]  tail_slot;
  } idll_rsp_t;

endpackage

`default_nettype wire

>>> design/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list with its slot memory and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Doubly linked list kept in one slot memory (used flag, prev, next, data per slot).
// Slot 0 is null; free slots form a stack threaded through next.
// Request channel: req_i is taken at a rising edge where start is high and busy is low.
// Result channel: rsp_o is valid for exactly one cycle while rsp_valid_o is high;
// the receiver cannot stall it. The result shows in the cycle in which busy falls, and a
// new request can be taken in that same cycle.
// Sequencer steps after the accepting edge, set by the one read and one write port of the
// slot memory:
//   bad position, full on empty list, empty ordinal, undefined action: answered from idle
//   read slot, insert into an empty list, error found at the slot: one slot read
//   insert after or before: position, free slot, link, then the neighbor if not null
//   remove: position, then one patch for each non-null neighbor
//   read nth: one slot read per step to reach the n-th element
// Reset puts the list empty with every slot but 0 on the free stack; slots not yet
// taken from the free stack read through a fill count, so no clearing pass is needed.
module indexed_doubly_linked_list
  import idll_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int DATA_WIDTH = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire idll_req_t req_i,
  output idll_rsp_t      rsp_o,
  output logic           rsp_valid_o
);

  localparam int IW = $clog2(SLOTS);

  typedef logic [IW-1:0]         idx_t;
  typedef logic [IW:0]           cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  used;
    idx_t  prev;
    idx_t  next;
    word_t data;
  } entry_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_NBR   = 3'd4;
  localparam logic [2:0] S_RM_PV = 3'd5;
  localparam logic [2:0] S_RM_NX = 3'd6;
  localparam logic [2:0] S_WALK  = 3'd7;

  function automatic idx_t fresh_next(idx_t a);
    if (32'(a) == SLOTS - 1) begin
      return '0;
    end
    return idx_t'(a + idx_t'(1));
  endfunction

  logic [2:0] state_q, state_d;
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  idx_t       ftop_q, ftop_d;
  cnt_t       fill_q, fill_d;
  logic [2:0] act_q, act_d;
  logic [7:0] pos_q, pos_d;
  word_t      val_q, val_d;
  logic       empty_q, empty_d;
  entry_t     ent_q, ent_d;
  idx_t       slot_q, slot_d;
  idx_t       cur_q, cur_d;
  logic [7:0] n_q, n_d;

  idll_rsp_t  rsp_q;
  logic       rsp_valid_q;

  // Slot memory
  entry_t     mem_q [SLOTS];
  entry_t     mem_rd_q;
  idx_t       rd_addr_q;
  logic       rd_fresh_q;
  entry_t     rd_ent;

  logic       rd_en;
  idx_t       rd_addr;
  logic       wr_en;
  idx_t       wr_addr;
  entry_t     wr_ent;

  logic       fin;
  logic [1:0] fin_status;
  idx_t       fin_slot;
  word_t      fin_data;

  idx_t       pos_idx;
  idx_t       in_pos_idx;
  logic       in_pos_ok;
  logic       list_empty;
  idx_t       nb_idx;

  assign pos_idx    = idx_t'(pos_q);
  assign in_pos_idx = idx_t'(req_i.position);
  assign in_pos_ok  = (req_i.position != 8'd0) && (32'(req_i.position) < SLOTS);
  assign list_empty = (head_q == '0) && (tail_q == '0);
  assign nb_idx     = (act_q == ACT_INS_AFTER) ? ent_q.next : ent_q.prev;

  // Slots at or above the fill count were never taken: they read as free and chained.
  always_comb begin
    rd_ent = mem_rd_q;
    if (rd_fresh_q) begin
      rd_ent.used = 1'b0;
      rd_ent.prev = '0;
      rd_ent.next = fresh_next(rd_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      mem_rd_q   <= mem_q[rd_addr];
      rd_addr_q  <= rd_addr;
      rd_fresh_q <= ({1'b0, rd_addr} >= fill_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ftop_d     = ftop_q;
    fill_d     = fill_q;
    act_d      = act_q;
    pos_d      = pos_q;
    val_d      = val_q;
    empty_d    = empty_q;
    ent_d      = ent_q;
    slot_d     = slot_q;
    cur_d      = cur_q;
    n_d        = n_q;
    rd_en      = 1'b0;
    rd_addr    = ftop_q;
    wr_en      = 1'b0;
    wr_addr    = pos_idx;
    wr_ent     = ent_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_slot   = '0;
    fin_data   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d   = req_i.action;
          pos_d   = req_i.position;
          val_d   = req_i.value[DATA_WIDTH-1:0];
          empty_d = 1'b0;
          if ((req_i.action inside {ACT_INS_AFTER, ACT_INS_BEFORE}) && list_empty) begin
            if (ftop_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              empty_d = 1'b1;
              rd_en   = 1'b1;
              rd_addr = ftop_q;
              state_d = S_FREE;
            end
          end else if (req_i.action inside {ACT_INS_AFTER, ACT_INS_BEFORE, ACT_REMOVE,
                                            ACT_READ_SLOT}) begin
            if (!in_pos_ok) begin
              fin        = 1'b1;
              fin_status = ST_BAD_SLOT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = in_pos_idx;
              state_d = S_POS;
            end
          end else if (req_i.action == ACT_READ_NTH) begin
            if (req_i.position == 8'd0 || head_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_NOT_FOUND;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              cur_d   = head_q;
              n_d     = 8'd1;
              state_d = S_WALK;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end

      S_POS: begin
        ent_d = rd_ent;
        if (!rd_ent.used) begin
          fin        = 1'b1;
          fin_status = ST_BAD_SLOT;
        end else if (act_q == ACT_READ_SLOT) begin
          fin      = 1'b1;
          fin_slot = pos_idx;
          fin_data = rd_ent.data;
        end else if (act_q == ACT_REMOVE) begin
          // free the slot now; neighbors are patched in the following cycles
          wr_en        = 1'b1;
          wr_addr      = pos_idx;
          wr_ent.used  = 1'b0;
          wr_ent.prev  = '0;
          wr_ent.next  = ftop_q;
          wr_ent.data  = '0;
          ftop_d       = pos_idx;
          slot_d       = pos_idx;
          if (rd_ent.prev == '0) begin
            head_d = rd_ent.next;
          end
          if (rd_ent.next == '0) begin
            tail_d = rd_ent.prev;
          end
          if (rd_ent.prev != '0) begin
            rd_en   = 1'b1;
            rd_addr = rd_ent.prev;
            state_d = S_RM_PV;
          end else if (rd_ent.next != '0) begin
            rd_en   = 1'b1;
            rd_addr = rd_ent.next;
            state_d = S_RM_NX;
          end else begin
            fin      = 1'b1;
            fin_slot = pos_idx;
          end
        end else if (ftop_q == '0) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ftop_q;
          state_d = S_FREE;
        end
      end

      S_FREE: begin
        // pop the free stack and fill the new slot
        ftop_d = rd_ent.next;
        if ({1'b0, ftop_q} == fill_q) begin
          fill_d = cnt_t'(fill_q + cnt_t'(1));
        end
        slot_d      = ftop_q;
        wr_en       = 1'b1;
        wr_addr     = ftop_q;
        wr_ent.used = 1'b1;
        wr_ent.data = val_q;
        if (empty_q) begin
          wr_ent.prev = '0;
          wr_ent.next = '0;
          head_d      = ftop_q;
          tail_d      = ftop_q;
          fin         = 1'b1;
          fin_slot    = ftop_q;
        end else begin
          if (act_q == ACT_INS_AFTER) begin
            wr_ent.prev = pos_idx;
            wr_ent.next = ent_q.next;
          end else begin
            wr_ent.prev = ent_q.prev;
            wr_ent.next = pos_idx;
          end
          if (nb_idx != '0) begin
            rd_en   = 1'b1;
            rd_addr = nb_idx;
          end
          state_d = S_LINK;
        end
      end

      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = pos_idx;
        wr_ent  = ent_q;
        if (act_q == ACT_INS_AFTER) begin
          wr_ent.next = slot_q;
        end else begin
          wr_ent.prev = slot_q;
        end
        if (nb_idx == '0) begin
          if (act_q == ACT_INS_AFTER) begin
            tail_d = slot_q;
          end else begin
            head_d = slot_q;
          end
          fin      = 1'b1;
          fin_slot = slot_q;
        end else begin
          state_d = S_NBR;
        end
      end

      S_NBR: begin
        // neighbor entry still sits in the read register
        wr_en   = 1'b1;
        wr_addr = nb_idx;
        wr_ent  = rd_ent;
        if (act_q == ACT_INS_AFTER) begin
          wr_ent.prev = slot_q;
        end else begin
          wr_ent.next = slot_q;
        end
        fin      = 1'b1;
        fin_slot = slot_q;
      end

      S_RM_PV: begin
        wr_en       = 1'b1;
        wr_addr     = ent_q.prev;
        wr_ent      = rd_ent;
        wr_ent.next = ent_q.next;
        if (ent_q.next != '0) begin
          rd_en   = 1'b1;
          rd_addr = ent_q.next;
          state_d = S_RM_NX;
        end else begin
          fin      = 1'b1;
          fin_slot = slot_q;
        end
      end

      S_RM_NX: begin
        wr_en       = 1'b1;
        wr_addr     = ent_q.next;
        wr_ent      = rd_ent;
        wr_ent.prev = ent_q.prev;
        fin         = 1'b1;
        fin_slot    = slot_q;
      end

      S_WALK: begin
        if (!rd_ent.used) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else if (n_q == pos_q) begin
          fin      = 1'b1;
          fin_slot = cur_q;
          fin_data = rd_ent.data;
        end else if (rd_ent.next == '0) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else begin
          // advance one element
          rd_en   = 1'b1;
          rd_addr = rd_ent.next;
          cur_d   = rd_ent.next;
          n_d     = 8'(n_q + 8'd1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ftop_q      <= idx_t'(1);
      fill_q      <= cnt_t'(1);
      act_q       <= ACT_INS_AFTER;
      empty_q     <= 1'b0;
      n_q         <= 8'd0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ftop_q      <= ftop_d;
      fill_q      <= fill_d;
      act_q       <= act_d;
      empty_q     <= empty_d;
      n_q         <= n_d;
      rsp_valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    ent_q  <= ent_d;
    slot_q <= slot_d;
    cur_q  <= cur_d;
    if (fin) begin
      rsp_q.status    <= fin_status;
      rsp_q.slot      <= 8'(fin_slot);
      rsp_q.data      <= 64'(fin_data);
      rsp_q.head_slot <= 8'(head_d);
      rsp_q.tail_slot <= 8'(tail_d);
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // Head and tail are null together or not at all.
  a_head_tail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == '0) == (tail_q == '0))
    else $error("head and tail disagree on an empty list");

  // A result is shown only once the sequencer is back in idle.
  a_rsp_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (state_q == S_IDLE))
    else $error("result strobe while sequencer busy");

  // The null slot is never written.
  a_no_null_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0))
    else $error("write to null slot");

  // Read and write in one cycle never touch the same slot.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write collide on one slot");

  // A free stack top in the untouched region is always the fill count itself.
  a_ftop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ftop_q} >= fill_q) |-> (({1'b0, ftop_q} == fill_q) || (ftop_q == '0)))
    else $error("free stack top skips untouched slots");

endmodule

`default_nettype wire

>>> verif/idll_checker.sv
// Checker for the indexed linked list: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module idll_checker
  import idll_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire idll_req_t req_i,
  input  wire idll_rsp_t rsp_i,
  input  wire logic      rsp_valid_i,
  output int             errors_o,
  output int             outstanding_o,
  output int             ok_seen_o,
  output int             bad_seen_o,
  output int             full_seen_o,
  output int             nf_seen_o
);

  logic [7:0]  link_next  [256];
  logic [7:0]  link_prev  [256];
  logic        occupied_q [256];
  logic [63:0] slot_word  [256];
  logic [7:0]  head_q;
  logic [7:0]  tail_q;
  logic [7:0]  free_head;
  idll_rsp_t   due_rsp_q  [$];

  function automatic logic occupied(input logic [7:0] s);
    return (s != 8'd0) && occupied_q[s];
  endfunction

  task automatic clear_list();
    for (int i = 0; i < 256; i++) begin
      link_next[i]  = (i < 255) ? 8'(i + 1) : 8'd0;
      link_prev[i]  = 8'd0;
      occupied_q[i] = 1'b0;
      slot_word[i]  = '0;
    end
    head_q    = 8'd0;
    tail_q    = 8'd0;
    free_head = 8'd1;
  endtask

  task automatic grab_free(input logic [63:0] v, output logic [7:0] s);
    s             = free_head;
    free_head     = link_next[s];
    occupied_q[s] = 1'b1;
    slot_word[s]  = v;
  endtask

  // Work out the list after one action and the result it reports.
  task automatic apply_list_action(input idll_req_t r, output idll_rsp_t e);
    logic [7:0] nx;
    logic [7:0] pv;
    logic [7:0] s;
    int         n;
    int         steps;
    bit         found;
    e = '0;
    e.status = ST_OK;
    case (r.action)
      ACT_INS_AFTER, ACT_INS_BEFORE: begin
        if (head_q == 8'd0 && tail_q == 8'd0) begin
          // empty list: position does not matter
          if (free_head == 8'd0) begin
            e.status = ST_FULL;
          end else begin
            grab_free(r.value, s);
            link_next[s] = 8'd0;
            link_prev[s] = 8'd0;
            head_q = s;
            tail_q = s;
            e.slot = s;
          end
        end else if (!occupied(r.position)) begin
          e.status = ST_BAD_SLOT;
        end else if (free_head == 8'd0) begin
          e.status = ST_FULL;
        end else if (r.action == ACT_INS_AFTER) begin
          nx = link_next[r.position];
          grab_free(r.value, s);
          link_next[s] = nx;
          link_prev[s] = r.position;
          link_next[r.position] = s;
          if (nx == 8'd0) tail_q = s;
          else link_prev[nx] = s;
          e.slot = s;
        end else begin
          pv = link_prev[r.position];
          grab_free(r.value, s);
          link_prev[s] = pv;
          link_next[s] = r.position;
          link_prev[r.position] = s;
          if (pv == 8'd0) head_q = s;
          else link_next[pv] = s;
          e.slot = s;
        end
      end
      ACT_REMOVE: begin
        if (!occupied(r.position)) begin
          e.status = ST_BAD_SLOT;
        end else begin
          nx = link_next[r.position];
          pv = link_prev[r.position];
          if (pv == 8'd0) head_q = nx;
          else link_next[pv] = nx;
          if (nx == 8'd0) tail_q = pv;
          else link_prev[nx] = pv;
          occupied_q[r.position] = 1'b0;
          slot_word[r.position]  = '0;
          link_prev[r.position]  = 8'd0;
          link_next[r.position]  = free_head;
          free_head = r.position;
          e.slot = r.position;
        end
      end
      ACT_READ_SLOT: begin
        if (!occupied(r.position)) begin
          e.status = ST_BAD_SLOT;
        end else begin
          e.slot = r.position;
          e.data = slot_word[r.position];
        end
      end
      ACT_READ_NTH: begin
        e.status = ST_NOT_FOUND;
        s     = head_q;
        n     = 1;
        steps = 0;
        found = 1'b0;
        while (!found && steps < 256 && occupied(s)) begin
          if (n == int'(r.position)) begin
            found    = 1'b1;
            e.status = ST_OK;
            e.slot   = s;
            e.data   = slot_word[s];
          end else begin
            s = link_next[s];
            n++;
            steps++;
          end
        end
      end
      default: ;
    endcase
    e.head_slot = head_q;
    e.tail_slot = tail_q;
  endtask

  task automatic flag(input string what, input idll_rsp_t want, input idll_rsp_t got);
    if (errors_o < 10) begin
      $display("%0t: %s: expected st=%0d slot=%0d data=%h head=%0d tail=%0d", $time, what,
               want.status, want.slot, want.data, want.head_slot, want.tail_slot);
      $display("%0t: %s:      got st=%0d slot=%0d data=%h head=%0d tail=%0d", $time, what,
               got.status, got.slot, got.data, got.head_slot, got.tail_slot);
    end
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    idll_rsp_t want;
    if (!rst_ni) begin
      clear_list();
      due_rsp_q.delete();
      errors_o    = 0;
      ok_seen_o   = 0;
      bad_seen_o  = 0;
      full_seen_o = 0;
      nf_seen_o   = 0;
    end else begin
      if (rsp_valid_i === 1'b1) begin
        if (due_rsp_q.size() == 0) begin
          flag("result with nothing due", '0, rsp_i);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.slot !== want.slot ||
              rsp_i.data !== want.data || rsp_i.head_slot !== want.head_slot ||
              rsp_i.tail_slot !== want.tail_slot)
            flag("result mismatch", want, rsp_i);
        end
        case (rsp_i.status)
          ST_OK:       ok_seen_o++;
          ST_BAD_SLOT: bad_seen_o++;
          ST_FULL:     full_seen_o++;
          default:     nf_seen_o++;
        endcase
      end
      // A new transfer may land on the same edge as the previous result.
      if (start === 1'b1 && busy === 1'b0) begin
        apply_list_action(req_i, want);
        due_rsp_q.push_back(want);
      end
    end
    outstanding_o = due_rsp_q.size();
  end

endmodule

>>> verif/tb_indexed_doubly_linked_list.sv
// Testbench top for the indexed linked list: reset, directed and random requests, verdict.
`timescale 1ns / 1ps

module tb_indexed_doubly_linked_list
  import idll_pkg::*;
();

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  idll_req_t req_i;
  idll_rsp_t rsp_o;
  logic      rsp_valid_o;

  int errors;
  int outstanding;
  int ok_n;
  int bad_n;
  int full_n;
  int nf_n;
  int sent;
  bit idle_on;

  // Stimulus hints only: actions in flight and slots believed to be on the list.
  logic [2:0] sent_act_q [$];
  logic [7:0] members    [$];

  indexed_doubly_linked_list u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  idll_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .rsp_i         (rsp_o),
    .rsp_valid_i   (rsp_valid_o),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .ok_seen_o     (ok_n),
    .bad_seen_o    (bad_n),
    .full_seen_o   (full_n),
    .nf_seen_o     (nf_n)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    logic [2:0] act;
    int         idx;
    if (rst_ni && rsp_valid_o === 1'b1 && sent_act_q.size() != 0) begin
      act = sent_act_q.pop_front();
      if (rsp_o.status == ST_OK) begin
        if (act == ACT_INS_AFTER || act == ACT_INS_BEFORE) begin
          members.push_back(rsp_o.slot);
        end else if (act == ACT_REMOVE) begin
          idx = -1;
          foreach (members[i]) if (members[i] == rsp_o.slot) idx = i;
          if (idx >= 0) members.delete(idx);
        end
      end
    end
  end

  // Drive one request at the falling edge and hold it until the transfer.
  task automatic send(input logic [2:0] act, input logic [7:0] pos, input logic [63:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          = 1'b1;
    req_i.action   = act;
    req_i.position = pos;
    req_i.value    = val;
    do @(posedge clk_i); while (busy !== 1'b0);
    sent_act_q.push_back(act);
    sent++;
  endtask

  function automatic logic [7:0] pick_slot();
    if (members.size() != 0 && $urandom_range(0, 99) < 85)
      return members[$urandom_range(0, members.size() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_phase(input int count, input int ins_pct, input int rem_pct);
    int         r;
    logic [2:0] act;
    logic [7:0] pos;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        act = $urandom_range(0, 1) ? ACT_INS_BEFORE : ACT_INS_AFTER;
        pos = pick_slot();
      end else if (r < ins_pct + rem_pct) begin
        act = ACT_REMOVE;
        pos = pick_slot();
      end else if ($urandom_range(0, 99) < 4) begin
        act = 3'(ACT_READ_NTH + 1 + $urandom_range(0, 2));
        pos = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 1)) begin
        act = ACT_READ_SLOT;
        pos = pick_slot();
      end else begin
        act = ACT_READ_NTH;
        pos = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, members.size() + 2))
                                           : 8'($urandom_range(0, 255));
      end
      send(act, pos, rand_word());
    end
  endtask

  initial begin
    int guard;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    sent    = 0;
    idle_on = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Empty list corners, then a three-element list built and torn down.
    send(ACT_READ_NTH,   8'd1,   '0);
    send(ACT_READ_NTH,   8'd0,   '0);
    send(ACT_READ_SLOT,  8'd0,   '0);
    send(ACT_REMOVE,     8'd0,   '0);
    send(ACT_REMOVE,     8'd255, '0);
    send(ACT_INS_AFTER,  8'd200, '1);
    send(ACT_INS_BEFORE, 8'd1,   '0);
    send(ACT_INS_AFTER,  8'd1,   64'hA5A5_5A5A_0F0F_F0F0);
    send(ACT_INS_AFTER,  8'd77,  '1);
    send(ACT_INS_BEFORE, 8'd0,   '1);
    send(ACT_READ_SLOT,  8'd1,   '0);
    send(ACT_READ_NTH,   8'd1,   '0);
    send(ACT_READ_NTH,   8'd3,   '0);
    send(ACT_READ_NTH,   8'd4,   '0);
    send(ACT_READ_NTH,   8'd255, '0);
    send(ACT_REMOVE,     8'd1,   '0);
    send(ACT_REMOVE,     8'd2,   '0);
    send(ACT_REMOVE,     8'd3,   '0);
    send(ACT_READ_SLOT,  8'd3,   '0);
    send(ACT_INS_BEFORE, 8'd0,   64'h0123_4567_89AB_CDEF);
    send(3'(ACT_READ_NTH + 1), 8'd3,   '1);
    send(3'(ACT_READ_NTH + 2), 8'd0,   '1);
    send(3'(ACT_READ_NTH + 3), 8'd255, '0);
    send(ACT_READ_SLOT,  8'd255, '0);

    // Grow, churn, fill past full, drain, churn again.
    random_phase(150, 70, 10);
    random_phase(300, 35, 30);
    random_phase(300, 92, 3);
    random_phase(250, 5, 75);
    random_phase(80, 40, 30);

    @(negedge clk_i) start = 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests; results: %0d ok, %0d bad slot, %0d full, %0d not found.",
             sent, ok_n, bad_n, full_n, nf_n);
    $display("Covered empty, single, full and drained lists with random gaps between requests.");
    if (errors == 0 && outstanding == 0) begin
      $display("tb_indexed_doubly_linked_list: done, clean");
    end else begin
      $display("tb_indexed_doubly_linked_list: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_indexed_doubly_linked_list: done, errors");
    $finish;
  end

endmodule
